### rtl/core/page_first_fit_allocator_core_defines.svh
// Assertion macros for the page allocator core.
`ifndef PAGE_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH
`define PAGE_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define PFFA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("pffa check failed");
`define PFFA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("pffa reset check failed");
`else
`define PFFA_ASSERT(lbl, prop)
`define PFFA_ASSERT_RST(lbl, prop)
`endif
`endif

### rtl/core/pffa_pkg.sv
// Shared types and constants for the page allocator core.
package pffa_pkg;
  localparam int PAGE_BYTES_DEF = 4096;
  localparam int MAX_PAGES_DEF  = 256;
  localparam logic [6:0] HDR_RESET = 7'd24;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  typedef struct packed {
    logic cs;
    logic used;
  } cell_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_APPLY  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;
endpackage

### rtl/core/pffa_cell.sv
// One page cell of the rotating page table.
module pffa_cell import pffa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift_en,
  input  cell_t d,
  output cell_t q
);
  cell_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift_en) begin
      q_r <= d;
    end
  end

  assign q = q_r;
endmodule

### rtl/core/page_first_fit_allocator_core.sv
// Top level of the page allocator core: controller and page cell ring.
// Usage: an allocate or free transaction enters on the in_ channel (valid/stall).
// The page table lives in a ring of MAX_PAGES cells that rotates one page per
// cycle past a single controller head while scanning or updating. Each
// transaction takes one full scan rotation, a decision step, then for a
// successful operation one update rotation; the result is then loaded into
// the output register once the output slot is free.
// in_stall is high while a transaction is in work; the next transaction is
// taken while a finished result still waits in the output register.
// The result is held in out_ registers until out_stall is low; a stalled
// result holds its payload, and the next result waits for the slot.
// cfg_we writes header_bytes; write only while idle.
// Synchronous reset clears all cells (empty heap, heap top zero) and sets
// header_bytes to 24; no clearing pass is needed.
`include "page_first_fit_allocator_core_defines.svh"
module page_first_fit_allocator_core import pffa_pkg::*; #(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int MAX_PAGES  = MAX_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [20:0] in_request_bytes,
  input  logic [19:0] in_payload_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] out_result_offset,
  output logic [1:0]  out_status,
  output logic [8:0]  out_heap_pages_used
);
  localparam int LPB = $clog2(PAGE_BYTES);
  localparam int PW  = $clog2(MAX_PAGES);
  localparam int CW  = $clog2(MAX_PAGES + 1);
  localparam int OW  = (CW + LPB > 20) ? CW + LPB : 20;
  localparam logic [PW-1:0] LAST_IDX = PW'(MAX_PAGES - 1);
  localparam logic [CW-1:0] NPAGES   = CW'(MAX_PAGES);

  cell_t cq [MAX_PAGES];
  cell_t head, wb;
  logic  shift_en;

  for (genvar g = 0; g < MAX_PAGES; g++) begin : g_cell
    cell_t d;
    if (g == MAX_PAGES - 1) begin : g_tail
      assign d = wb;
    end else begin : g_mid
      assign d = cq[g+1];
    end
    pffa_cell u_cell (.clk(clk), .rst_n(rst_n), .shift_en(shift_en), .d(d), .q(cq[g]));
  end
  assign head = cq[0];

  state_t state_r, state_nxt;
  logic [6:0]    hdr_r;
  logic [CW-1:0] top_r;
  logic [PW-1:0] cnt_r;
  logic          op_r, big_r, inval_r;
  logic [CW-1:0] n_r;
  logic [PW-1:0] p_r;
  // alloc scan
  logic [PW-1:0] cur_s_r, fit_s_r;
  logic          cur_free_r, found_r;
  logic [CW-1:0] fit_len_r;
  // free scan
  logic [PW-1:0] prev_s_r;
  logic          prev_free_r, has_prev_r, csp_r, up_r, e_found_r, ue_r;
  logic [CW-1:0] e_r;
  // update pass
  logic [CW-1:0] lo_r, hi_r, a1_r, a2_r;
  logic          set_u_r, en1_r, v1_r, en2_r, v2_r;
  // result
  logic          out_valid_r;
  logic [19:0]   res_off_r, out_off_r;
  logic [1:0]    res_st_r, out_st_r;
  logic [8:0]    out_top_r;

  logic in_acc, out_acc, last_cyc;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign last_cyc = (cnt_r == LAST_IDX);
  assign shift_en = (state_r == S_SCAN) || (state_r == S_APPLY);

  // request sizing and free address checks
  logic [21:0] total;
  logic [22:0] need_w, need_z;
  logic [19:0] q_off, pg;
  logic        bad_free;
  assign total  = {1'b0, in_request_bytes} + 22'(hdr_r);
  assign need_w = (23'(total) + 23'(PAGE_BYTES - 1)) >> LPB;
  assign need_z = (need_w == '0) ? 23'd1 : need_w;
  assign q_off  = in_payload_offset - 20'(hdr_r);
  assign pg     = q_off >> LPB;
  assign bad_free = (in_payload_offset < 20'(hdr_r)) || (q_off[LPB-1:0] != '0) ||
                    (32'(pg) >= 32'(top_r));

  // head position
  logic [CW-1:0] idx;
  logic          in_heap, bnd, at_top;
  assign idx     = CW'(cnt_r);
  assign in_heap = idx < top_r;
  assign bnd     = in_heap && ((cnt_r == '0) || head.cs);
  assign at_top  = (idx == top_r) && (top_r != '0);

  // chunk close checks for the alloc scan
  logic          close_a, ok_a, close_b, ok_b;
  logic [PW-1:0] s_b;
  logic          free_b;
  logic [CW-1:0] len_a, len_b;
  assign close_a = (bnd && (cnt_r != '0)) || at_top;
  assign len_a   = idx - CW'(cur_s_r);
  assign ok_a    = close_a && cur_free_r && (len_a >= n_r);
  assign s_b     = bnd ? cnt_r : cur_s_r;
  assign free_b  = bnd ? !head.used : cur_free_r;
  assign close_b = last_cyc && (top_r == NPAGES);
  assign len_b   = NPAGES - CW'(s_b);
  assign ok_b    = close_b && free_b && (len_b >= n_r);

  // update pass writeback
  always_comb begin
    wb = head;
    if (state_r == S_APPLY) begin
      if (idx >= lo_r && idx < hi_r) wb.used = set_u_r;
      if (en1_r && idx == a1_r) wb.cs = v1_r;
      if (en2_r && idx == a2_r) wb.cs = v2_r;
    end
  end

  // decision
  logic [CW-1:0] g_start;
  logic [CW:0]   g_end;
  logic [OW-1:0] off_w;
  logic [CW-1:0] st_sel;
  assign g_start = ((top_r != '0) && cur_free_r) ? CW'(cur_s_r) : top_r;
  assign g_end   = {1'b0, g_start} + {1'b0, n_r};
  assign st_sel  = found_r ? CW'(fit_s_r) : g_start;
  assign off_w   = (OW'(st_sel) << LPB) + OW'(hdr_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_SCAN;
      S_SCAN:   if (last_cyc) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (op_r == OP_ALLOC) begin
          state_nxt = (big_r || (!found_r && g_end > (CW+1)'(MAX_PAGES))) ? S_DONE : S_APPLY;
        end else begin
          state_nxt = (inval_r || !csp_r || !up_r) ? S_DONE : S_APPLY;
        end
      end
      S_APPLY:  if (last_cyc) state_nxt = S_DONE;
      S_DONE:   if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hdr_r       <= HDR_RESET;
      top_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) hdr_r <= cfg_wdata;
      if (shift_en) cnt_r <= last_cyc ? '0 : cnt_r + 1'b1;
      if (state_r == S_DECIDE && state_nxt == S_APPLY && op_r == OP_ALLOC && !found_r)
        top_r <= g_end[CW-1:0];
      if (state_r == S_DONE && state_nxt == S_IDLE) out_valid_r <= 1'b1;
      else if (out_acc) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r       <= in_opcode;
      big_r      <= need_z > 23'(MAX_PAGES);
      n_r        <= CW'(need_z);
      inval_r    <= bad_free;
      p_r        <= PW'(32'(pg));
      cur_s_r    <= '0;
      cur_free_r <= 1'b0;
      found_r    <= 1'b0;
      fit_s_r    <= '0;
      fit_len_r  <= '0;
      prev_s_r   <= '0;
      prev_free_r <= 1'b0;
      has_prev_r <= 1'b0;
      csp_r      <= 1'b0;
      up_r       <= 1'b0;
      e_found_r  <= 1'b0;
      ue_r       <= 1'b0;
      e_r        <= top_r;
    end
    if (state_r == S_SCAN) begin
      if (bnd) begin
        cur_s_r    <= cnt_r;
        cur_free_r <= !head.used;
      end
      if (!found_r) begin
        if (ok_a) begin
          found_r <= 1'b1; fit_s_r <= cur_s_r; fit_len_r <= len_a;
        end else if (ok_b) begin
          found_r <= 1'b1; fit_s_r <= s_b; fit_len_r <= len_b;
        end
      end
      if (bnd && cnt_r < p_r) begin
        prev_s_r <= cnt_r; prev_free_r <= !head.used; has_prev_r <= 1'b1;
      end
      if (cnt_r == p_r) begin
        csp_r <= head.cs; up_r <= head.used;
      end
      if (!e_found_r && cnt_r > p_r && in_heap && head.cs) begin
        e_found_r <= 1'b1; e_r <= idx; ue_r <= head.used;
      end
    end
    if (state_r == S_DECIDE) begin
      res_off_r <= 20'd0;
      en1_r     <= 1'b0;
      en2_r     <= 1'b0;
      if (op_r == OP_ALLOC) begin
        if (state_nxt == S_APPLY) begin
          res_st_r  <= ST_OK;
          res_off_r <= off_w[19:0];
          lo_r      <= st_sel;
          hi_r      <= st_sel + n_r;
          set_u_r   <= 1'b1;
          a1_r      <= st_sel;  v1_r <= 1'b1; en1_r <= !found_r;
          a2_r      <= st_sel + n_r; v2_r <= 1'b1; en2_r <= found_r && (fit_len_r > n_r);
        end else begin
          res_st_r <= ST_OOM;
        end
      end else begin
        res_st_r <= (state_nxt == S_APPLY) ? ST_OK : ST_BADFREE;
        lo_r     <= CW'(p_r);
        hi_r     <= e_r;
        set_u_r  <= 1'b0;
        a1_r     <= e_r;       v1_r <= 1'b0; en1_r <= (e_r < top_r) && !ue_r;
        a2_r     <= CW'(p_r);  v2_r <= 1'b0; en2_r <= has_prev_r && prev_free_r;
      end
    end
    if (state_r == S_DONE && state_nxt == S_IDLE) begin
      out_off_r <= res_off_r;
      out_st_r  <= res_st_r;
      out_top_r <= 9'(top_r);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_offset   = out_off_r;
  assign out_status          = out_st_r;
  assign out_heap_pages_used = out_top_r;

  `PFFA_ASSERT_RST(a_top_mono, $past(rst_n) && rst_n |-> top_r >= $past(top_r))
  `PFFA_ASSERT(a_top_bound, top_r <= NPAGES)
  `PFFA_ASSERT(a_ring_aligned, (state_r == S_DECIDE || state_r == S_IDLE) |-> cnt_r == '0)
  `PFFA_ASSERT(a_result_held, out_valid_r && out_stall |=> out_valid_r && $stable(out_off_r))
endmodule
